// ----- rtl/bank_pitch_envelope_limiter_assert.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the bank and pitch envelope limiter
// Implication helpers that share the clock and the active-low reset.
// ---------------------------------------------------------------------------
`ifndef BANK_PITCH_ENVELOPE_LIMITER_ASSERT_SVH
`define BANK_PITCH_ENVELOPE_LIMITER_ASSERT_SVH

// Same-cycle implication.
`define BPEL_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define BPEL_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/bpel_pkg.sv -----
// ---------------------------------------------------------------------------
// Envelope limiter package
// Widths, servo constants, register codes and pipeline stage types.
// ---------------------------------------------------------------------------
package bpel_pkg;

  localparam int ANG_W      = 9;   // angles and thresholds, signed degrees
  localparam int CMD_W      = 12;  // servo pulse widths, us
  localparam int NUM_W      = 10;  // difference of two magnitudes
  localparam int MAG_W      = 9;   // magnitude of an angle, up to 256
  localparam int PROD_W     = 21;  // magnitude times servo half-range
  localparam int QUO_W      = 12;  // quotient bits
  localparam int DIV_STEPS  = 3;   // quotient bits per divider stage
  localparam int DIV_STAGES = QUO_W / DIV_STEPS;
  localparam int PIPE_DEPTH = DIV_STAGES + 3;

  localparam logic [CMD_W-1:0] ELEV_MIN_US = 12'd1000;
  localparam logic [CMD_W-1:0] ELEV_MID_US = 12'd1500;
  localparam logic [CMD_W-1:0] ELEV_MAX_US = 12'd2000;
  localparam logic [CMD_W-1:0] AIL_MIN_US  = 12'd1000;
  localparam logic [CMD_W-1:0] AIL_MID_US  = 12'd1500;
  localparam logic [CMD_W-1:0] AIL_MAX_US  = 12'd2000;

  localparam int CFG_NUM   = 8;
  localparam int CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PITCH_UP_UNSAFE    = 3'd0,
    CFG_PITCH_UP_EXTREME   = 3'd1,
    CFG_PITCH_DOWN_UNSAFE  = 3'd2,
    CFG_PITCH_DOWN_EXTREME = 3'd3,
    CFG_ROLL_RIGHT_UNSAFE  = 3'd4,
    CFG_ROLL_RIGHT_EXTREME = 3'd5,
    CFG_ROLL_LEFT_UNSAFE   = 3'd6,
    CFG_ROLL_LEFT_EXTREME  = 3'd7
  } cfg_idx_e;

  localparam logic signed [ANG_W-1:0] CFG_RESET [CFG_NUM] = '{
    -9'sd30, -9'sd60, 9'sd30, 9'sd60, -9'sd45, -9'sd80, 9'sd45, 9'sd80
  };

  // How the mapped value is merged into the command.
  typedef enum logic [1:0] {
    OP_PASS = 2'd0,
    OP_MIN  = 2'd1,
    OP_MAX  = 2'd2
  } op_e;

  // Where the mapped value comes from.
  typedef enum logic [1:0] {
    V_MID = 2'd0,
    V_LIM = 2'd1,
    V_DIV = 2'd2
  } mode_e;

  // Thresholds of one axis: branch a tests angle <= unsafe_a, branch b >= unsafe_b.
  typedef struct packed {
    logic signed [ANG_W-1:0] unsafe_a;
    logic signed [ANG_W-1:0] extreme_a;
    logic signed [ANG_W-1:0] unsafe_b;
    logic signed [ANG_W-1:0] extreme_b;
  } thr_t;

  typedef struct packed {
    logic [CMD_W-1:0] mid;
    logic [CMD_W-1:0] lim_a;
    logic [CMD_W-1:0] lim_b;
    op_e              op_a;
    op_e              op_b;
  } axis_cfg_t;

  typedef struct packed {
    op_e                     op;
    logic [CMD_W-1:0]        cmd;
    logic [CMD_W-1:0]        mid;
    logic [CMD_W-1:0]        lim;
    logic signed [NUM_W-1:0] num;
    logic signed [NUM_W-1:0] den;
  } s1_t;

  typedef struct packed {
    op_e               op;
    logic [CMD_W-1:0]  cmd;
    logic [CMD_W-1:0]  mid;
    logic [CMD_W-1:0]  lim;
    mode_e             mode;
    logic              up;
    logic [PROD_W-1:0] rem;
    logic [MAG_W-1:0]  den;
    logic [QUO_W-1:0]  quo;
  } div_t;

  function automatic logic [MAG_W-1:0] abs9(input logic signed [ANG_W-1:0] v);
    return v[ANG_W-1] ? (~v + 9'd1) : v;
  endfunction

  function automatic logic [MAG_W-1:0] abs10(input logic signed [NUM_W-1:0] v);
    logic [NUM_W-1:0] r;
    r = v[NUM_W-1] ? (~v + 10'd1) : v;
    return r[MAG_W-1:0];
  endfunction

endpackage

// ----- rtl/bpel_if.sv -----
// ---------------------------------------------------------------------------
// Envelope limiter stream interfaces
// Valid/ready channels for sensor-and-command words and limited commands.
// ---------------------------------------------------------------------------
interface bpel_in_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [bpel_pkg::ANG_W-1:0]    pitch_deg;
  logic signed [bpel_pkg::ANG_W-1:0]    roll_deg;
  logic        [bpel_pkg::CMD_W-1:0]    pitch_cmd_in;
  logic        [bpel_pkg::CMD_W-1:0]    roll_cmd_in;
  logic                                 limiter_on;

  modport source (output valid, pitch_deg, roll_deg, pitch_cmd_in, roll_cmd_in,
                  limiter_on, input ready);
  modport sink   (input valid, pitch_deg, roll_deg, pitch_cmd_in, roll_cmd_in,
                  limiter_on, output ready);
endinterface

interface bpel_out_if;
  logic                         valid;
  logic                         ready;
  logic [bpel_pkg::CMD_W-1:0]   pitch_cmd_out;
  logic [bpel_pkg::CMD_W-1:0]   roll_cmd_out;

  modport source (output valid, pitch_cmd_out, roll_cmd_out, input ready);
  modport sink   (input valid, pitch_cmd_out, roll_cmd_out, output ready);
endinterface

// ----- rtl/bpel_front.sv -----
// ---------------------------------------------------------------------------
// Envelope limiter front end
// Branch select and magnitudes, then the product and the mapping mode.
// ---------------------------------------------------------------------------
module bpel_front (
  input  logic                              clk_i,
  input  logic                              en_s1_i,
  input  logic                              en_s2_i,
  input  logic signed [bpel_pkg::ANG_W-1:0] angle_i,
  input  logic        [bpel_pkg::CMD_W-1:0] cmd_i,
  input  logic                              on_i,
  input  bpel_pkg::thr_t                    thr_i,
  input  bpel_pkg::axis_cfg_t               acfg_i,
  output bpel_pkg::div_t                    div_o
);

  bpel_pkg::s1_t  s1_d, s1_q;
  bpel_pkg::div_t s2_d, s2_q;

  logic                              sel_a, sel_b;
  logic signed [bpel_pkg::ANG_W-1:0] unsafe, extreme;

  // Stage 1: pick the branch, take magnitudes and their differences.
  always_comb begin
    sel_a   = on_i && (angle_i <= thr_i.unsafe_a);
    sel_b   = on_i && !sel_a && (angle_i >= thr_i.unsafe_b);
    unsafe  = sel_a ? thr_i.unsafe_a  : thr_i.unsafe_b;
    extreme = sel_a ? thr_i.extreme_a : thr_i.extreme_b;
    s1_d.op  = sel_a ? acfg_i.op_a : (sel_b ? acfg_i.op_b : bpel_pkg::OP_PASS);
    s1_d.cmd = cmd_i;
    s1_d.mid = acfg_i.mid;
    s1_d.lim = sel_a ? acfg_i.lim_a : acfg_i.lim_b;
    s1_d.num = 10'({1'b0, bpel_pkg::abs9(angle_i)}) - 10'({1'b0, bpel_pkg::abs9(unsafe)});
    s1_d.den = 10'({1'b0, bpel_pkg::abs9(extreme)}) - 10'({1'b0, bpel_pkg::abs9(unsafe)});
  end

  always_ff @(posedge clk_i) begin
    if (en_s1_i) begin
      s1_q <= s1_d;
    end
  end

  logic [bpel_pkg::MAG_W-1:0] anum, aden;
  logic [bpel_pkg::CMD_W-1:0] adelta;
  logic                       up;

  // Stage 2: magnitude product and the cases that need no quotient.
  always_comb begin
    anum   = bpel_pkg::abs10(s1_q.num);
    aden   = bpel_pkg::abs10(s1_q.den);
    up     = s1_q.lim > s1_q.mid;
    adelta = up ? (s1_q.lim - s1_q.mid) : (s1_q.mid - s1_q.lim);
    s2_d.op  = s1_q.op;
    s2_d.cmd = s1_q.cmd;
    s2_d.mid = s1_q.mid;
    s2_d.lim = s1_q.lim;
    s2_d.up  = up;
    s2_d.rem = {12'd0, anum} * {9'd0, adelta};
    s2_d.den = aden;
    s2_d.quo = '0;
    if (s1_q.den == '0) begin
      s2_d.mode = bpel_pkg::V_LIM;        // zero span saturates to the far limit
    end else if (s1_q.num[bpel_pkg::NUM_W-1] ^ s1_q.den[bpel_pkg::NUM_W-1]) begin
      s2_d.mode = bpel_pkg::V_MID;        // quotient points away from the limit
    end else if (anum >= aden) begin
      s2_d.mode = bpel_pkg::V_LIM;        // quotient reaches the half-range
    end else begin
      s2_d.mode = bpel_pkg::V_DIV;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_s2_i) begin
      s2_q <= s2_d;
    end
  end

  assign div_o = s2_q;

endmodule

// ----- rtl/bpel_div_stage.sv -----
// ---------------------------------------------------------------------------
// Envelope limiter divider stage
// Restoring long division, a few quotient bits per stage.
// ---------------------------------------------------------------------------
module bpel_div_stage (
  input  logic           clk_i,
  input  logic           en_i,
  input  bpel_pkg::div_t d_i,
  output bpel_pkg::div_t d_o
);

  bpel_pkg::div_t               d_d, d_q;
  logic [bpel_pkg::PROD_W-1:0]  r, dsh;
  logic [bpel_pkg::QUO_W-1:0]   q;

  always_comb begin
    d_d = d_i;
    r   = d_i.rem;
    q   = d_i.quo;
    dsh = 21'(d_i.den) << (bpel_pkg::QUO_W - 1);
    for (int i = 0; i < bpel_pkg::DIV_STEPS; i++) begin
      if (r >= dsh) begin
        r = r - dsh;
        q = {q[bpel_pkg::QUO_W-2:0], 1'b1};
      end else begin
        q = {q[bpel_pkg::QUO_W-2:0], 1'b0};
      end
      r = r << 1;
    end
    d_d.rem = r;
    d_d.quo = q;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      d_q <= d_d;
    end
  end

  assign d_o = d_q;

endmodule

// ----- rtl/bpel_out_stage.sv -----
// ---------------------------------------------------------------------------
// Envelope limiter output stage
// Build the mapped command and merge it with the requested one.
// ---------------------------------------------------------------------------
module bpel_out_stage (
  input  logic                       clk_i,
  input  logic                       en_i,
  input  bpel_pkg::div_t             d_i,
  output logic [bpel_pkg::CMD_W-1:0] cmd_o
);

  logic [bpel_pkg::CMD_W:0]   sum;
  logic [bpel_pkg::CMD_W-1:0] v, cmd_d, cmd_q;

  always_comb begin
    sum = d_i.up ? ({1'b0, d_i.mid} + {1'b0, d_i.quo})
                 : ({1'b0, d_i.mid} - {1'b0, d_i.quo});
    case (d_i.mode)
      bpel_pkg::V_LIM: v = d_i.lim;
      bpel_pkg::V_DIV: v = sum[bpel_pkg::CMD_W-1:0];
      default:         v = d_i.mid;
    endcase
    case (d_i.op)
      bpel_pkg::OP_MIN: cmd_d = (v < d_i.cmd) ? v : d_i.cmd;
      bpel_pkg::OP_MAX: cmd_d = (v > d_i.cmd) ? v : d_i.cmd;
      default:          cmd_d = d_i.cmd;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cmd_q <= cmd_d;
    end
  end

  assign cmd_o = cmd_q;

endmodule

// ----- rtl/bank_pitch_envelope_limiter.sv -----
// Throughput: one word per cycle; back-pressure holds only the occupied tail.
// The depth is set by the quotient: four divider stages of three bits each,
// behind a select stage and a multiply stage, then the output register.
// Reset: thresholds return to their defaults, all stage valid bits clear.
// ---------------------------------------------------------------------------
// Bank and pitch envelope limiter
// Limits elevator and aileron commands when pitch or roll leave the envelope.
// ---------------------------------------------------------------------------
module bank_pitch_envelope_limiter #(
  parameter logic [bpel_pkg::CMD_W-1:0] ELEV_MIN_US = bpel_pkg::ELEV_MIN_US,
  parameter logic [bpel_pkg::CMD_W-1:0] ELEV_MID_US = bpel_pkg::ELEV_MID_US,
  parameter logic [bpel_pkg::CMD_W-1:0] ELEV_MAX_US = bpel_pkg::ELEV_MAX_US,
  parameter logic [bpel_pkg::CMD_W-1:0] AIL_MIN_US  = bpel_pkg::AIL_MIN_US,
  parameter logic [bpel_pkg::CMD_W-1:0] AIL_MID_US  = bpel_pkg::AIL_MID_US,
  parameter logic [bpel_pkg::CMD_W-1:0] AIL_MAX_US  = bpel_pkg::AIL_MAX_US
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [bpel_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic signed [bpel_pkg::ANG_W-1:0]     cfg_data_i,
  bpel_in_if.sink                               in_i,
  bpel_out_if.source                            out_o
);

  // -------------------------------------------------------------------------
  // Threshold registers, to be written by the user only while the pipeline is empty; the block does not enforce it.
  // -------------------------------------------------------------------------
  logic signed [bpel_pkg::ANG_W-1:0] cfg_q [bpel_pkg::CFG_NUM];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < bpel_pkg::CFG_NUM; i++) begin
        cfg_q[i] <= bpel_pkg::CFG_RESET[i];
      end
    end else if (cfg_we_i) begin
      cfg_q[cfg_idx_i] <= cfg_data_i;
    end
  end

  // -------------------------------------------------------------------------
  // Per-axis branch wiring. Pitch: nose-up first (toward elevator minimum,
  // keep the smaller command), then nose-down. Roll: right bank first
  // (toward aileron maximum, keep the larger), then left bank.
  // -------------------------------------------------------------------------
  bpel_pkg::thr_t      pitch_thr, roll_thr;
  bpel_pkg::axis_cfg_t pitch_acfg, roll_acfg;

  always_comb begin
    pitch_thr.unsafe_a  = cfg_q[bpel_pkg::CFG_PITCH_UP_UNSAFE];
    pitch_thr.extreme_a = cfg_q[bpel_pkg::CFG_PITCH_UP_EXTREME];
    pitch_thr.unsafe_b  = cfg_q[bpel_pkg::CFG_PITCH_DOWN_UNSAFE];
    pitch_thr.extreme_b = cfg_q[bpel_pkg::CFG_PITCH_DOWN_EXTREME];
    roll_thr.unsafe_a   = cfg_q[bpel_pkg::CFG_ROLL_RIGHT_UNSAFE];
    roll_thr.extreme_a  = cfg_q[bpel_pkg::CFG_ROLL_RIGHT_EXTREME];
    roll_thr.unsafe_b   = cfg_q[bpel_pkg::CFG_ROLL_LEFT_UNSAFE];
    roll_thr.extreme_b  = cfg_q[bpel_pkg::CFG_ROLL_LEFT_EXTREME];

    pitch_acfg.mid   = ELEV_MID_US;
    pitch_acfg.lim_a = ELEV_MIN_US;
    pitch_acfg.op_a  = bpel_pkg::OP_MIN;
    pitch_acfg.lim_b = ELEV_MAX_US;
    pitch_acfg.op_b  = bpel_pkg::OP_MAX;

    roll_acfg.mid    = AIL_MID_US;
    roll_acfg.lim_a  = AIL_MAX_US;
    roll_acfg.op_a   = bpel_pkg::OP_MAX;
    roll_acfg.lim_b  = AIL_MIN_US;
    roll_acfg.op_b   = bpel_pkg::OP_MIN;
  end

  // -------------------------------------------------------------------------
  // Valid chain. A stage loads when it is empty or the stage after it loads,
  // so bubbles collapse and a stall freezes exactly the occupied tail.
  // Stage 0 select, 1 multiply, 2..5 divide, 6 output register.
  // -------------------------------------------------------------------------
  logic [bpel_pkg::PIPE_DEPTH-1:0] vld_q, vld_d, en;

  always_comb begin
    en[bpel_pkg::PIPE_DEPTH-1] = !vld_q[bpel_pkg::PIPE_DEPTH-1] || out_o.ready;
    for (int k = bpel_pkg::PIPE_DEPTH - 2; k >= 0; k--) begin
      en[k] = !vld_q[k] || en[k+1];
    end
    vld_d = vld_q;
    if (en[0]) begin
      vld_d[0] = in_i.valid;
    end
    for (int k = 1; k < bpel_pkg::PIPE_DEPTH; k++) begin
      if (en[k]) begin
        vld_d[k] = vld_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign in_i.ready  = en[0];
  assign out_o.valid = vld_q[bpel_pkg::PIPE_DEPTH-1];

  // -------------------------------------------------------------------------
  // Datapath: two identical axis pipelines.
  // -------------------------------------------------------------------------
  bpel_pkg::div_t pitch_div [bpel_pkg::DIV_STAGES+1];
  bpel_pkg::div_t roll_div  [bpel_pkg::DIV_STAGES+1];

  bpel_front u_pitch_front (
    .clk_i   (clk_i),
    .en_s1_i (en[0]),
    .en_s2_i (en[1]),
    .angle_i (in_i.pitch_deg),
    .cmd_i   (in_i.pitch_cmd_in),
    .on_i    (in_i.limiter_on),
    .thr_i   (pitch_thr),
    .acfg_i  (pitch_acfg),
    .div_o   (pitch_div[0])
  );

  bpel_front u_roll_front (
    .clk_i   (clk_i),
    .en_s1_i (en[0]),
    .en_s2_i (en[1]),
    .angle_i (in_i.roll_deg),
    .cmd_i   (in_i.roll_cmd_in),
    .on_i    (in_i.limiter_on),
    .thr_i   (roll_thr),
    .acfg_i  (roll_acfg),
    .div_o   (roll_div[0])
  );

  for (genvar g = 0; g < bpel_pkg::DIV_STAGES; g++) begin : g_div
    bpel_div_stage u_pitch_div (
      .clk_i (clk_i),
      .en_i  (en[g+2]),
      .d_i   (pitch_div[g]),
      .d_o   (pitch_div[g+1])
    );

    bpel_div_stage u_roll_div (
      .clk_i (clk_i),
      .en_i  (en[g+2]),
      .d_i   (roll_div[g]),
      .d_o   (roll_div[g+1])
    );
  end

  bpel_out_stage u_pitch_out (
    .clk_i (clk_i),
    .en_i  (en[bpel_pkg::PIPE_DEPTH-1]),
    .d_i   (pitch_div[bpel_pkg::DIV_STAGES]),
    .cmd_o (out_o.pitch_cmd_out)
  );

  bpel_out_stage u_roll_out (
    .clk_i (clk_i),
    .en_i  (en[bpel_pkg::PIPE_DEPTH-1]),
    .d_i   (roll_div[bpel_pkg::DIV_STAGES]),
    .cmd_o (out_o.roll_cmd_out)
  );

endmodule

// ----- rtl/bpel_checker.sv -----
// ---------------------------------------------------------------------------
// Envelope limiter port checker
// Watches occupancy and handshake behavior on the top-level ports.
// ---------------------------------------------------------------------------
`include "bank_pitch_envelope_limiter_assert.svh"

module bpel_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_ready_i,
  input logic                       out_valid_i,
  input logic                       out_ready_i,
  input logic [bpel_pkg::CMD_W-1:0] pitch_out_i,
  input logic [bpel_pkg::CMD_W-1:0] roll_out_i
);

  localparam int CNT_W = $clog2(bpel_pkg::PIPE_DEPTH + 2);

  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             in_acc, out_acc;

  assign in_acc  = in_valid_i && in_ready_i;
  assign out_acc = out_valid_i && out_ready_i;

  // Count words inside the block.
  always_comb begin
    cnt_d = cnt_q;
    if (in_acc && !out_acc) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!in_acc && out_acc) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  `BPEL_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i && $stable(pitch_out_i) && $stable(roll_out_i), "stalled result word changed or dropped")
  `BPEL_ASSERT_IMP(a_ready_when_drained, clk_i, rst_ni, !out_valid_i, in_ready_i, "input stalled while output register empty")
  `BPEL_ASSERT_IMP(a_occupancy_bound, clk_i, rst_ni, 1'b1, cnt_q <= CNT_W'(bpel_pkg::PIPE_DEPTH), "more words in flight than pipeline stages")
  `BPEL_ASSERT_IMP(a_no_phantom, clk_i, rst_ni, out_valid_i, cnt_q != '0, "result word with no accepted input word")

endmodule

bind bank_pitch_envelope_limiter bpel_checker u_bpel_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .pitch_out_i (out_o.pitch_cmd_out),
  .roll_out_i  (out_o.roll_cmd_out)
);

// ----- tb/bpel_limit_checker.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Envelope limiter result checker
// Watches the input and output channels and the threshold port, works out
// the limited commands of every accepted word and compares each result word.
// ---------------------------------------------------------------------------
module bpel_limit_checker (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [bpel_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic signed [bpel_pkg::ANG_W-1:0] cfg_data_i,
  bpel_in_if                                in_mon_i,
  bpel_out_if                               out_mon_i,
  output int                                fail_count_o,
  output int                                outstanding_o,
  output int                                checked_o,
  output int                                altered_o
);
  import bpel_pkg::*;

  typedef struct packed {
    logic [CMD_W-1:0] pitch_cmd;
    logic [CMD_W-1:0] roll_cmd;
  } servo_pair_t;

  localparam int THR_DEFAULT [CFG_NUM] = '{-30, -60, 30, 60, -45, -80, 45, 80};

  int          thr [CFG_NUM];
  servo_pair_t expected_cmds [$];

  function automatic int magnitude(input int v);
    return (v < 0) ? -v : v;
  endfunction

  // Map an angle past its unsafe threshold onto mid..lim, then clamp.
  function automatic int envelope_cmd(input int angle, input int unsafe_deg,
                                      input int extreme_deg, input int mid,
                                      input int lim);
    int span;
    int v;
    int lo_bound;
    int hi_bound;
    span     = magnitude(extreme_deg) - magnitude(unsafe_deg);
    lo_bound = (mid < lim) ? mid : lim;
    hi_bound = (mid < lim) ? lim : mid;
    if (span == 0) begin
      v = lim;
    end else begin
      v = (magnitude(angle) - magnitude(unsafe_deg)) * (lim - mid) / span + mid;
    end
    if (v < lo_bound) begin
      v = lo_bound;
    end else if (v > hi_bound) begin
      v = hi_bound;
    end
    return v;
  endfunction

  function automatic servo_pair_t limit_commands(input int pitch, input int roll,
                                                 input int pcmd, input int rcmd,
                                                 input logic on);
    servo_pair_t r;
    int          m;
    if (on) begin
      // Nose-up test wins when both pitch tests hold.
      if (pitch <= thr[CFG_PITCH_UP_UNSAFE]) begin
        m = envelope_cmd(pitch, thr[CFG_PITCH_UP_UNSAFE], thr[CFG_PITCH_UP_EXTREME],
                         int'(ELEV_MID_US), int'(ELEV_MIN_US));
        if (m < pcmd) pcmd = m;
      end else if (pitch >= thr[CFG_PITCH_DOWN_UNSAFE]) begin
        m = envelope_cmd(pitch, thr[CFG_PITCH_DOWN_UNSAFE], thr[CFG_PITCH_DOWN_EXTREME],
                         int'(ELEV_MID_US), int'(ELEV_MAX_US));
        if (m > pcmd) pcmd = m;
      end
      // Right-bank test wins when both roll tests hold.
      if (roll <= thr[CFG_ROLL_RIGHT_UNSAFE]) begin
        m = envelope_cmd(roll, thr[CFG_ROLL_RIGHT_UNSAFE], thr[CFG_ROLL_RIGHT_EXTREME],
                         int'(AIL_MID_US), int'(AIL_MAX_US));
        if (m > rcmd) rcmd = m;
      end else if (roll >= thr[CFG_ROLL_LEFT_UNSAFE]) begin
        m = envelope_cmd(roll, thr[CFG_ROLL_LEFT_UNSAFE], thr[CFG_ROLL_LEFT_EXTREME],
                         int'(AIL_MID_US), int'(AIL_MIN_US));
        if (m < rcmd) rcmd = m;
      end
    end
    r.pitch_cmd = pcmd[CMD_W-1:0];
    r.roll_cmd  = rcmd[CMD_W-1:0];
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    servo_pair_t want;
    if (!rst_ni) begin
      foreach (thr[i]) thr[i] = THR_DEFAULT[i];
      expected_cmds.delete();
      fail_count_o  = 0;
      outstanding_o = 0;
      checked_o     = 0;
      altered_o     = 0;
    end else begin
      if (cfg_we_i) begin
        thr[cfg_idx_i] = cfg_data_i;
      end
      // Check the result word first; a word accepted now cannot come out now.
      if (out_mon_i.valid && out_mon_i.ready) begin
        if (expected_cmds.size() == 0) begin
          fail_count_o++;
          $display("%0t: result word %0d/%0d with no input word waiting",
                   $time, out_mon_i.pitch_cmd_out, out_mon_i.roll_cmd_out);
        end else begin
          want = expected_cmds.pop_front();
          checked_o++;
          if (out_mon_i.pitch_cmd_out !== want.pitch_cmd) begin
            fail_count_o++;
            $display("%0t: elevator command expected %0d, got %0d",
                     $time, want.pitch_cmd, out_mon_i.pitch_cmd_out);
          end
          if (out_mon_i.roll_cmd_out !== want.roll_cmd) begin
            fail_count_o++;
            $display("%0t: aileron command expected %0d, got %0d",
                     $time, want.roll_cmd, out_mon_i.roll_cmd_out);
          end
        end
      end
      if (in_mon_i.valid && in_mon_i.ready) begin
        want = limit_commands(in_mon_i.pitch_deg, in_mon_i.roll_deg,
                              in_mon_i.pitch_cmd_in, in_mon_i.roll_cmd_in,
                              in_mon_i.limiter_on);
        if (want != {in_mon_i.pitch_cmd_in, in_mon_i.roll_cmd_in}) altered_o++;
        expected_cmds.push_back(want);
      end
      outstanding_o = expected_cmds.size();
    end
  end

endmodule

// ----- tb/bank_pitch_envelope_limiter_test.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Envelope limiter testbench
// Drives sensor-and-command words through the limiter under a series of
// threshold settings, with random gaps and stalls on both channels; a
// checker beside the block predicts and compares every result word.
// ---------------------------------------------------------------------------
module bank_pitch_envelope_limiter_test;
  import bpel_pkg::*;

  logic                    clk_i;
  logic                    rst_ni;
  logic                    cfg_we_i;
  cfg_idx_e                cfg_idx_i;
  logic signed [ANG_W-1:0] cfg_data_i;

  int fail_count;
  int outstanding;
  int checked;
  int altered;
  int words_sent;
  int settings_loaded;

  // calm: no idling on either side; hold_req: ask the receiver for a long stall.
  bit calm;
  bit hold_req;

  bpel_in_if  in_w ();
  bpel_out_if out_w ();

  bank_pitch_envelope_limiter dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_w),
    .out_o      (out_w)
  );

  bpel_limit_checker limit_check (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .in_mon_i      (in_w),
    .out_mon_i     (out_w),
    .fail_count_o  (fail_count),
    .outstanding_o (outstanding),
    .checked_o     (checked),
    .altered_o     (altered)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Hard stop: far beyond the slowest legal run.
  initial begin
    #1_000_000;
    $display("tb: failure");
    $finish;
  end

  // Receiver: drop ready at random, hold off for a long stretch on request,
  // and keep ready high throughout a calm phase.
  initial begin
    out_w.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        // Hold long enough for every stage to fill and the input to stall.
        out_w.ready <= 1'b0;
        repeat (120) @(negedge clk_i);
        hold_req = 1'b0;
      end
      out_w.ready <= calm || ($urandom_range(99) >= 15);
    end
  end

  // Offer one word; return at the falling edge after it was taken, with
  // valid still high so back-to-back words need no second assignment.
  task automatic send_word(input int pitch, input int roll, input int pcmd,
                           input int rcmd, input bit on);
    while (!calm && $urandom_range(99) < 15) begin
      in_w.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_w.valid        <= 1'b1;
    in_w.pitch_deg    <= pitch[ANG_W-1:0];
    in_w.roll_deg     <= roll[ANG_W-1:0];
    in_w.pitch_cmd_in <= pcmd[CMD_W-1:0];
    in_w.roll_cmd_in  <= rcmd[CMD_W-1:0];
    in_w.limiter_on   <= on;
    do @(posedge clk_i); while (in_w.ready !== 1'b1);
    @(negedge clk_i);
    words_sent++;
  endtask

  // Stop offering and wait until every expected result word has come back.
  task automatic drain_results();
    in_w.valid <= 1'b0;
    do @(negedge clk_i); while (outstanding != 0);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input int value);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value[ANG_W-1:0];
    @(negedge clk_i);
  endtask

  // Write all eight thresholds; call only with the block idle.
  task automatic load_envelope(input int pu_u, input int pu_e, input int pd_u,
                               input int pd_e, input int rr_u, input int rr_e,
                               input int rl_u, input int rl_e);
    write_reg(CFG_PITCH_UP_UNSAFE,    pu_u);
    write_reg(CFG_PITCH_UP_EXTREME,   pu_e);
    write_reg(CFG_PITCH_DOWN_UNSAFE,  pd_u);
    write_reg(CFG_PITCH_DOWN_EXTREME, pd_e);
    write_reg(CFG_ROLL_RIGHT_UNSAFE,  rr_u);
    write_reg(CFG_ROLL_RIGHT_EXTREME, rr_e);
    write_reg(CFG_ROLL_LEFT_UNSAFE,   rl_u);
    write_reg(CFG_ROLL_LEFT_EXTREME,  rl_e);
    cfg_we_i <= 1'b0;
    settings_loaded++;
  endtask

  // wild: any 9-bit pattern; otherwise a plausible envelope around level
  // flight, which now and then gives a zero span.
  task automatic random_envelope(input bit wild);
    int pu_u, pu_e, pd_u, pd_e, rr_u, rr_e, rl_u, rl_e;
    if (wild) begin
      pu_u = $urandom_range(511); pu_e = $urandom_range(511);
      pd_u = $urandom_range(511); pd_e = $urandom_range(511);
      rr_u = $urandom_range(511); rr_e = $urandom_range(511);
      rl_u = $urandom_range(511); rl_e = $urandom_range(511);
    end else begin
      pu_u = -int'($urandom_range(90));
      pu_e = pu_u - int'($urandom_range(90));
      pd_u = int'($urandom_range(90));
      pd_e = pd_u + int'($urandom_range(90));
      rr_u = -int'($urandom_range(90));
      rr_e = rr_u - int'($urandom_range(90));
      rl_u = int'($urandom_range(90));
      rl_e = rl_u + int'($urandom_range(90));
    end
    load_envelope(pu_u, pu_e, pd_u, pd_e, rr_u, rr_e, rl_u, rl_e);
  endtask

  initial begin
    int pitch, roll, pcmd, rcmd;
    bit on;

    // Start every input from a known value and hold reset.
    rst_ni            = 1'b0;
    cfg_we_i          = 1'b0;
    cfg_idx_i         = CFG_PITCH_UP_UNSAFE;
    cfg_data_i        = '0;
    in_w.valid        = 1'b0;
    in_w.pitch_deg    = '0;
    in_w.roll_deg     = '0;
    in_w.pitch_cmd_in = '0;
    in_w.roll_cmd_in  = '0;
    in_w.limiter_on   = 1'b0;
    calm              = 1'b0;
    hold_req          = 1'b0;
    words_sent        = 0;
    settings_loaded   = 0;
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed words under the reset thresholds.
    send_word(0, 0, 1500, 1500, 1'b1);          // level flight, nothing to do
    send_word(-30, 0, 1500, 1500, 1'b1);        // right on the nose-up threshold
    send_word(-45, 0, 1500, 1500, 1'b1);        // halfway into nose-up limiting
    send_word(-60, 0, 2000, 1500, 1'b1);        // nose-up extreme
    send_word(-180, 0, 4095, 0, 1'b1);          // far past extreme, clamp
    send_word(-256, -256, 4095, 0, 1'b1);       // most negative 9-bit angles
    send_word(-60, 0, 900, 1500, 1'b1);         // command already more corrective
    send_word(30, 0, 1500, 1500, 1'b1);         // nose-down threshold
    send_word(45, 0, 0, 1500, 1'b1);
    send_word(180, 180, 0, 4095, 1'b1);
    send_word(255, 255, 0, 4095, 1'b1);         // most positive 9-bit angles
    send_word(0, -45, 1500, 1500, 1'b1);        // right-bank threshold
    send_word(0, -62, 1000, 1500, 1'b1);        // truncating division
    send_word(0, -80, 0, 4095, 1'b1);           // aileron already past limit
    send_word(0, 45, 1500, 1500, 1'b1);         // left-bank threshold
    send_word(0, 80, 4095, 4095, 1'b1);
    send_word(-180, 180, 1234, 2345, 1'b0);     // disabled, pass through
    send_word(255, -256, 4095, 4095, 1'b0);

    // Overlapping thresholds: both tests hold on each axis, zero spans on
    // pitch, and an extreme nearer than the unsafe angle on left bank.
    drain_results();
    load_envelope(20, -20, -20, 20, 10, -90, -10, 5);
    send_word(0, 0, 1500, 1500, 1'b1);
    send_word(-20, -10, 2000, 1000, 1'b1);
    send_word(25, -5, 1500, 1500, 1'b1);
    send_word(-100, 100, 3000, 100, 1'b1);

    // Random words in six phases, each under its own thresholds.
    for (int ph = 0; ph < 6; ph++) begin
      drain_results();
      case (ph)
        0:       load_envelope(-30, -60, 30, 60, -45, -80, 45, 80);
        1:       load_envelope(0, -180, 0, 180, -1, -180, 1, 180);
        2, 5:    random_envelope(1'b0);
        3:       load_envelope(255, -256, -256, 255, -180, 180, 180, -180);
        default: random_envelope(1'b1);
      endcase
      calm = (ph == 2);
      for (int k = 0; k < 150; k++) begin
        // Stall the output for a long stretch while words keep coming.
        if (ph == 1 && k == 40) hold_req = 1'b1;
        // Pause the sender until the pipeline has emptied.
        if (ph == 4 && k == 75) drain_results();
        pitch = ($urandom_range(99) < 80) ? int'($urandom_range(360)) - 180
                                          : int'($urandom_range(511));
        roll  = ($urandom_range(99) < 80) ? int'($urandom_range(360)) - 180
                                          : int'($urandom_range(511));
        pcmd  = ($urandom_range(99) < 70) ? int'($urandom_range(2100, 900))
                                          : int'($urandom_range(4095));
        rcmd  = ($urandom_range(99) < 70) ? int'($urandom_range(2100, 900))
                                          : int'($urandom_range(4095));
        on    = ($urandom_range(99) < 85);
        send_word(pitch, roll, pcmd, rcmd, on);
      end
    end
    calm = 1'b0;

    // Let the last words come out, then allow a few spare cycles for strays.
    drain_results();
    repeat (16) @(negedge clk_i);

    $display("summary: %0d words under %0d threshold settings, %0d results checked",
             words_sent, settings_loaded + 1, checked);
    $display("summary: %0d results altered by limiting, with one long output stall",
             altered);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
